### src/ffba_pkg.sv
// package for the first-fit block allocator
// holds default sizes, field widths, command and status codes and the sequencer state type
// no dependencies
package ffba_pkg;

   localparam int unsigned MemCellsDefault = 128;
   localparam int unsigned MaxIdsDefault   = 255;

   localparam int unsigned CMD_W    = 2;
   localparam int unsigned SIZE_W   = 8;
   localparam int unsigned TID_W    = 8;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned ISSUED_W = 8;
   localparam int unsigned MSIZE_W  = 8;
   localparam int unsigned REQ_W    = 24;
   localparam int unsigned RSP_W    = 16;

   localparam logic [MSIZE_W-1:0] MSIZE_RESET = 8'd128;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ERASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PACK  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ILLEGAL   = 2'd2;

   typedef enum logic [2:0] {
      ST_ZERO,
      ST_IDLE,
      ST_ALLOC_SCAN,
      ST_ALLOC_FILL,
      ST_ERASE_SCAN,
      ST_PACK_SCAN,
      ST_RESP
   } state_type;

endpackage

### src/first_fit_block_allocator_top.sv
// first-fit block allocator with compaction: cell store in one synchronous ram,
// one sequencer that scans, fills, erases and packs one cell per cycle
// depends on ffba_pkg
//
//   channel  dir  handshake              contents
//   req_     in   req_tvalid/req_tready  command, request_size, target_id
//   rsp_     out  rsp_tvalid/rsp_tready  status, issued_id
//   csr_     in   csr_we                 memory_size
//
// one item at a time. alloc scans the usable cells (limit = memory_size saturated at
// MEM_CELLS) for a free run of the request size and then fills it; erase and defragment
// each scan the whole store, and defragment then clears the freed tail cells.
// the pace is set by the single ram port pair, one cell read and one written per cycle.
// after reset a clearing pass writes every cell once before req_tready rises.
// a result waits in the output register while rsp_tready is low.
module first_fit_block_allocator_top #(
   parameter int unsigned MEM_CELLS = ffba_pkg::MemCellsDefault,
   parameter int unsigned MAX_IDS   = ffba_pkg::MaxIdsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // command [1:0], request_size [9:2], target_id [17:10], zero [23:18]
   input  logic [ffba_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // status [1:0], issued_id [9:2], zero [15:10]
   output logic [ffba_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                          csr_we,
   input  logic [ffba_pkg::MSIZE_W-1:0]  csr_wdata
);

   localparam int unsigned AW   = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
   localparam int unsigned CW   = $clog2(MEM_CELLS + 1);
   localparam int unsigned LW   = (CW > 8) ? CW : 8;
   localparam int unsigned ID_W = $clog2(MAX_IDS + 1);
   localparam int unsigned NW   = ID_W + 1;
   localparam int unsigned IW   = (ID_W > 8) ? ID_W : 8;
   localparam logic [ffba_pkg::TID_W-1:0] TidMax =
      (MAX_IDS >= 255) ? 8'd255 : 8'(MAX_IDS);

   // request fields
   logic [ffba_pkg::CMD_W-1:0]  req_cmd;
   logic [ffba_pkg::SIZE_W-1:0] req_size;
   logic [ffba_pkg::TID_W-1:0]  req_tid;
   assign req_cmd  = req_tdata[1:0];
   assign req_size = req_tdata[9:2];
   assign req_tid  = req_tdata[17:10];

   // cell store
   logic [ID_W-1:0] cells [MEM_CELLS];
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [ID_W-1:0] mem_wdata;
   logic [AW-1:0]   mem_raddr;
   logic [ID_W-1:0] mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= cells[mem_raddr];
   end

   ffba_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  addr_ff, addr_in;
   logic [AW-1:0]  proc_addr_ff, proc_addr_in;
   logic           pend_ff, pend_in;
   logic [CW-1:0]  run_ff, run_in;
   logic [CW-1:0]  len_ff, len_in;
   logic [CW-1:0]  end_ff, end_in;
   logic [CW-1:0]  wptr_ff, wptr_in;
   logic           found_ff, found_in;
   logic [ffba_pkg::TID_W-1:0]    tid_ff, tid_in;
   logic [NW-1:0]                 next_id_ff, next_id_in;
   logic [ffba_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ffba_pkg::ISSUED_W-1:0] res_id_ff, res_id_in;
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [ffba_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ffba_pkg::ISSUED_W-1:0] rsp_id_ff, rsp_id_in;
   logic [ffba_pkg::MSIZE_W-1:0]  memory_size_ff;

   // usable cells, saturated at the store size
   logic [LW-1:0] limit_l;
   logic [CW-1:0] limit_c;
   assign limit_l = (LW'(memory_size_ff) > LW'(MEM_CELLS)) ? LW'(MEM_CELLS)
                                                           : LW'(memory_size_ff);
   assign limit_c = CW'(limit_l);

   always_ff @(posedge clock) begin
      if (reset) begin
         memory_size_ff <= ffba_pkg::MSIZE_RESET;
      end else if (csr_we) begin
         memory_size_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ffba_pkg::ST_ZERO;
         addr_ff       <= '0;
         pend_ff       <= 1'b0;
         next_id_ff    <= NW'(1);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         pend_ff       <= pend_in;
         next_id_ff    <= next_id_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      proc_addr_ff  <= proc_addr_in;
      run_ff        <= run_in;
      len_ff        <= len_in;
      end_ff        <= end_in;
      wptr_ff       <= wptr_in;
      found_ff      <= found_in;
      tid_ff        <= tid_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      proc_addr_in  = proc_addr_ff;
      pend_in       = 1'b0;
      run_in        = run_ff;
      len_in        = len_ff;
      end_in        = end_ff;
      wptr_in       = wptr_ff;
      found_in      = found_ff;
      tid_in        = tid_ff;
      next_id_in    = next_id_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      mem_we        = 1'b0;
      mem_waddr     = proc_addr_ff;
      mem_wdata     = '0;
      mem_raddr     = addr_ff[AW-1:0];
      req_tready    = 1'b0;

      case (state_ff)
         ffba_pkg::ST_ZERO: begin
            // clears from addr_ff to the top: reset pass and tail of a defragment
            if (addr_ff < CW'(MEM_CELLS)) begin
               mem_we    = 1'b1;
               mem_waddr = addr_ff[AW-1:0];
               addr_in   = addr_ff + 1'b1;
            end else begin
               state_in = ffba_pkg::ST_IDLE;
            end
         end

         ffba_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               addr_in  = '0;
               run_in   = '0;
               wptr_in  = '0;
               found_in = 1'b0;
               tid_in   = req_tid;
               case (req_cmd)
                  ffba_pkg::CMD_ALLOC: begin
                     if (next_id_ff > NW'(MAX_IDS) || req_size == '0 ||
                         LW'(req_size) > limit_l) begin
                        res_status_in = ffba_pkg::STATUS_NULL;
                        res_id_in     = '0;
                        state_in      = ffba_pkg::ST_RESP;
                     end else begin
                        len_in   = CW'(req_size);
                        state_in = ffba_pkg::ST_ALLOC_SCAN;
                     end
                  end
                  ffba_pkg::CMD_ERASE: begin
                     if (req_tid == '0 || req_tid > TidMax) begin
                        res_status_in = ffba_pkg::STATUS_ILLEGAL;
                        res_id_in     = '0;
                        state_in      = ffba_pkg::ST_RESP;
                     end else begin
                        state_in = ffba_pkg::ST_ERASE_SCAN;
                     end
                  end
                  default: begin
                     state_in = ffba_pkg::ST_PACK_SCAN;
                  end
               endcase
            end
         end

         ffba_pkg::ST_ALLOC_SCAN: begin
            if (addr_ff < limit_c) begin
               addr_in      = addr_ff + 1'b1;
               pend_in      = 1'b1;
               proc_addr_in = addr_ff[AW-1:0];
            end
            if (pend_ff) begin
               if (mem_rdata_ff == '0) begin
                  if (run_ff + 1'b1 == len_ff) begin
                     // run ends at proc_addr, fill from its start
                     end_in   = CW'(proc_addr_ff) + 1'b1;
                     addr_in  = CW'(proc_addr_ff) + 1'b1 - len_ff;
                     pend_in  = 1'b0;
                     state_in = ffba_pkg::ST_ALLOC_FILL;
                  end else begin
                     run_in = run_ff + 1'b1;
                  end
               end else begin
                  run_in = '0;
               end
            end else if (addr_ff >= limit_c) begin
               res_status_in = ffba_pkg::STATUS_NULL;
               res_id_in     = '0;
               state_in      = ffba_pkg::ST_RESP;
            end
         end

         ffba_pkg::ST_ALLOC_FILL: begin
            if (addr_ff != end_ff) begin
               mem_we    = 1'b1;
               mem_waddr = addr_ff[AW-1:0];
               mem_wdata = next_id_ff[ID_W-1:0];
               addr_in   = addr_ff + 1'b1;
            end else begin
               res_status_in = ffba_pkg::STATUS_ALLOCATED;
               res_id_in     = ffba_pkg::ISSUED_W'(next_id_ff);
               next_id_in    = next_id_ff + 1'b1;
               state_in      = ffba_pkg::ST_RESP;
            end
         end

         ffba_pkg::ST_ERASE_SCAN: begin
            if (addr_ff < CW'(MEM_CELLS)) begin
               addr_in      = addr_ff + 1'b1;
               pend_in      = 1'b1;
               proc_addr_in = addr_ff[AW-1:0];
            end
            if (pend_ff) begin
               if (IW'(mem_rdata_ff) == IW'(tid_ff)) begin
                  mem_we    = 1'b1;
                  mem_waddr = proc_addr_ff;
                  mem_wdata = '0;
                  found_in  = 1'b1;
               end
            end else if (addr_ff >= CW'(MEM_CELLS)) begin
               // an id owns cells exactly while it is live
               if (found_ff) begin
                  state_in = ffba_pkg::ST_IDLE;
               end else begin
                  res_status_in = ffba_pkg::STATUS_ILLEGAL;
                  res_id_in     = '0;
                  state_in      = ffba_pkg::ST_RESP;
               end
            end
         end

         ffba_pkg::ST_PACK_SCAN: begin
            if (addr_ff < CW'(MEM_CELLS)) begin
               addr_in      = addr_ff + 1'b1;
               pend_in      = 1'b1;
               proc_addr_in = addr_ff[AW-1:0];
            end
            if (pend_ff) begin
               // write pointer never passes the read pointer
               if (mem_rdata_ff != '0) begin
                  mem_we    = 1'b1;
                  mem_waddr = wptr_ff[AW-1:0];
                  mem_wdata = mem_rdata_ff;
                  wptr_in   = wptr_ff + 1'b1;
               end
            end else if (addr_ff >= CW'(MEM_CELLS)) begin
               addr_in  = wptr_ff;
               state_in = ffba_pkg::ST_ZERO;
            end
         end

         ffba_pkg::ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               state_in      = ffba_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ffba_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'd0, rsp_id_ff, rsp_status_ff};

endmodule
